[rtl/drls_pkg.sv]
// Shared types and constants of the decimal real literal scanner.
package drls_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MantW      = 63;
  localparam int unsigned ExpW       = 19;
  localparam int unsigned CountW     = 16;

  localparam logic [MantW-1:0]  MantLimit = 63'd922337203685477580;
  localparam logic [CountW-1:0] Sat16     = 16'hFFFF;

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrLowE  = 8'h65;
  localparam logic [7:0] ChrUpE   = 8'h45;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;

  typedef enum logic [2:0] {
    KindOther = 3'd0,
    KindDigit = 3'd1,
    KindMinus = 3'd2,
    KindPlus  = 3'd3,
    KindDot   = 3'd4,
    KindExp   = 3'd5,
    KindNul   = 3'd6
  } kind_e;

  typedef struct packed {
    logic       first;
    kind_e      kind;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } queue_status_t;

endpackage

[rtl/drls_front.sv]
// Input side: accepts text bytes and classifies them into queue items.
module drls_front (
  input  logic                   first_byte_i,
  input  logic [7:0]             byte_value_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  drls_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output drls_pkg::item_t        item_o
);
  import drls_pkg::*;

  logic [7:0] digit_off;

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign digit_off  = byte_value_i - ChrZero;

  always_comb begin
    item_o.first = first_byte_i;
    item_o.digit = digit_off[3:0];
    priority if (byte_value_i >= ChrZero && byte_value_i <= ChrNine) begin
      item_o.kind = KindDigit;
    end else if (byte_value_i == ChrNul) begin
      item_o.kind = KindNul;
    end else if (byte_value_i == ChrMinus) begin
      item_o.kind = KindMinus;
    end else if (byte_value_i == ChrPlus) begin
      item_o.kind = KindPlus;
    end else if (byte_value_i == ChrDot) begin
      item_o.kind = KindDot;
    end else if (byte_value_i == ChrLowE || byte_value_i == ChrUpE) begin
      item_o.kind = KindExp;
    end else begin
      item_o.kind = KindOther;
    end
  end

endmodule

[rtl/drls_queue.sv]
// Short FIFO of classified items between the front and back stages.
module drls_queue #(
  parameter int unsigned Depth = drls_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  drls_pkg::item_t         item_i,
  input  logic                    pop_i,
  output drls_pkg::item_t         head_o,
  output drls_pkg::queue_status_t status_o
);
  import drls_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/drls_back.sv]
// Scan engine: runs the literal state machine and holds the result register.
module drls_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  drls_pkg::item_t                head_i,
  input  drls_pkg::queue_status_t        q_status_i,
  output logic                           pop_o,
  output logic                           found_o,
  output logic                           negative_o,
  output logic [drls_pkg::MantW-1:0]     mantissa_o,
  output logic signed [drls_pkg::ExpW-1:0] decimal_exponent_o,
  output logic [drls_pkg::CountW-1:0]    consumed_length_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i
);
  import drls_pkg::*;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhSkip    = 5'b00010,
    PhMant    = 5'b00100,
    PhExpSign = 5'b01000,
    PhExpDig  = 5'b10000
  } phase_e;

  function automatic logic [CountW-1:0] inc16(input logic [CountW-1:0] v);
    inc16 = (v == Sat16) ? Sat16 : v + 1'b1;
  endfunction

  phase_e            phase_q, phase_d, ph;
  logic              sign_q, sign_d, cur_sign;
  logic [MantW-1:0]  sum_q, sum_d, cur_sum;
  logic [CountW-1:0] drop_q, drop_d, cur_drop;
  logic [CountW-1:0] frac_q, frac_d, cur_frac;
  logic              point_q, point_d, cur_point;
  logic              esign_q, esign_d, cur_esign;
  logic [CountW-1:0] exp_q, exp_d, cur_exp;
  logic [CountW-1:0] pos_q, pos_d, cur_pos;
  logic              do_mant, do_exp, emit, emit_found, first;
  logic [MantW-1:0]  sum_next;
  logic [CountW+3:0] exp_next;
  logic signed [ExpW-1:0] net;

  logic              out_valid_q;
  logic              found_q, negative_q;
  logic [MantW-1:0]  mant_q;
  logic signed [ExpW-1:0] dexp_q;
  logic [CountW-1:0] len_q;

  // Advance one item whenever the queue is not empty and the result register can take a new result.
  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign first = head_i.first;

  assign sum_next = (cur_sum << 3) + (cur_sum << 1) + MantW'(head_i.digit);
  assign exp_next = ({4'b0, cur_exp} << 3) + ({4'b0, cur_exp} << 1)
                  + (CountW + 4)'(head_i.digit);

  always_comb begin
    ph         = first ? PhSkip : phase_q;
    cur_sign   = first ? 1'b0 : sign_q;
    cur_sum    = first ? '0 : sum_q;
    cur_drop   = first ? '0 : drop_q;
    cur_frac   = first ? '0 : frac_q;
    cur_point  = first ? 1'b0 : point_q;
    cur_esign  = first ? 1'b0 : esign_q;
    cur_exp    = first ? '0 : exp_q;
    cur_pos    = first ? '0 : pos_q;

    phase_d    = ph;
    sign_d     = cur_sign;
    sum_d      = cur_sum;
    drop_d     = cur_drop;
    frac_d     = cur_frac;
    point_d    = cur_point;
    esign_d    = cur_esign;
    exp_d      = cur_exp;
    pos_d      = cur_pos;
    do_mant    = 1'b0;
    do_exp     = 1'b0;
    emit       = 1'b0;
    emit_found = 1'b0;

    unique case (ph)
      PhIdle: begin
      end
      PhSkip: begin
        priority if (head_i.kind == KindNul) begin
          emit = 1'b1;
        end else if (head_i.kind == KindMinus) begin
          sign_d  = 1'b1;
          pos_d   = inc16(cur_pos);
          phase_d = PhMant;
        end else if (head_i.kind == KindDigit) begin
          do_mant = 1'b1;
          phase_d = PhMant;
        end else begin
          pos_d = inc16(cur_pos);
        end
      end
      PhMant: begin
        priority if (head_i.kind == KindDigit) begin
          do_mant = 1'b1;
        end else if (head_i.kind == KindDot && !cur_point) begin
          point_d = 1'b1;
          pos_d   = inc16(cur_pos);
        end else if (head_i.kind == KindExp) begin
          phase_d = PhExpSign;
          pos_d   = inc16(cur_pos);
        end else begin
          emit       = 1'b1;
          emit_found = 1'b1;
        end
      end
      PhExpSign: begin
        priority if (head_i.kind == KindMinus || head_i.kind == KindPlus) begin
          esign_d = (head_i.kind == KindMinus);
          pos_d   = inc16(cur_pos);
          phase_d = PhExpDig;
        end else if (head_i.kind == KindDigit) begin
          do_exp  = 1'b1;
          phase_d = PhExpDig;
        end else begin
          emit       = 1'b1;
          emit_found = 1'b1;
        end
      end
      PhExpDig: begin
        if (head_i.kind == KindDigit) begin
          do_exp = 1'b1;
        end else begin
          emit       = 1'b1;
          emit_found = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    if (do_mant) begin
      if (cur_sum < MantLimit) begin
        sum_d = sum_next;
      end else begin
        drop_d = inc16(cur_drop);
      end
      if (cur_point) begin
        frac_d = inc16(cur_frac);
      end
      pos_d = inc16(cur_pos);
    end

    if (do_exp) begin
      exp_d = (exp_next < (CountW + 4)'(Sat16)) ? exp_next[CountW-1:0] : Sat16;
      pos_d = inc16(cur_pos);
    end

    if (emit) begin
      phase_d = PhIdle;
    end
  end

  always_comb begin
    net = ExpW'(cur_drop) - ExpW'(cur_frac);
    net = cur_esign ? net - ExpW'(cur_exp) : net + ExpW'(cur_exp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sign_q  <= sign_d;
      sum_q   <= sum_d;
      drop_q  <= drop_d;
      frac_q  <= frac_d;
      point_q <= point_d;
      esign_q <= esign_d;
      exp_q   <= exp_d;
      pos_q   <= pos_d;
    end
    if (pop_o && emit) begin
      found_q    <= emit_found;
      negative_q <= emit_found && cur_sign;
      mant_q     <= emit_found ? cur_sum : '0;
      dexp_q     <= emit_found ? net : '0;
      len_q      <= cur_pos;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign negative_o         = negative_q;
  assign mantissa_o         = mant_q;
  assign decimal_exponent_o = dexp_q;
  assign consumed_length_o  = len_q;

endmodule

[rtl/decimal_real_literal_scanner.sv]
// Path: the ending byte is written into the item queue, then a scan step pops it and
// loads the result register; queued items ahead or an output stall delay that step.
// Throughput: one byte per cycle unless the output stalls, set by the scan engine's
// multiply-by-ten add; the item queue absorbs output stalls before in_ready_o drops.
// Reset: rst_ni clears the queue, the scan phase (idle) and the result valid flag;
// the scanner waits for a byte marked as the first of a string.
module decimal_real_literal_scanner #(
  parameter int unsigned QueueDepth = drls_pkg::QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               first_byte_i,
  input  logic [7:0]                         byte_value_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic                               found_o,
  output logic                               negative_o,
  output logic [drls_pkg::MantW-1:0]         mantissa_o,
  output logic signed [drls_pkg::ExpW-1:0]   decimal_exponent_o,
  output logic [drls_pkg::CountW-1:0]        consumed_length_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import drls_pkg::*;

  item_t         push_item, head_item;
  queue_status_t q_status;
  logic          push, pop;

  drls_front u_front (
    .first_byte_i (first_byte_i),
    .byte_value_i (byte_value_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (push_item)
  );

  drls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  drls_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head_item),
    .q_status_i         (q_status),
    .pop_o              (pop),
    .found_o            (found_o),
    .negative_o         (negative_o),
    .mantissa_o         (mantissa_o),
    .decimal_exponent_o (decimal_exponent_o),
    .consumed_length_o  (consumed_length_o),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i)
  );

endmodule

[rtl/drls_checker.sv]
// Port-level checks of the literal scanner and their binding to the top level.
module drls_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               first_byte_i,
  input logic [7:0]                         byte_value_i,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               found_o,
  input logic                               negative_o,
  input logic [drls_pkg::MantW-1:0]         mantissa_o,
  input logic signed [drls_pkg::ExpW-1:0]   decimal_exponent_o,
  input logic [drls_pkg::CountW-1:0]        consumed_length_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o)
      && $stable(negative_o) && $stable(mantissa_o)
      && $stable(decimal_exponent_o) && $stable(consumed_length_o))
    else $error("result changed while stalled");

  // A scan that hit the terminator first reports no number.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> !negative_o && mantissa_o == '0
      && decimal_exponent_o == '0)
    else $error("empty scan carries number fields");

  // A minus sign or a nonzero mantissa means at least one byte was consumed.
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && (negative_o || mantissa_o != '0)
      |-> consumed_length_o != '0)
    else $error("number reported with zero length");

  // Input backpressure only follows a stalled output.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule

bind decimal_real_literal_scanner drls_checker u_drls_checker (.*);
